// File: hw/rtl/tdsd_pkg.sv
`default_nettype none

package tdsd_pkg;

  localparam int NumChannels  = 12;
  localparam int ChIdxW       = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int CycleBytes   = 70;
  localparam int RefBytes     = 15;
  localparam int CycleSamples = 85;
  localparam int SingleByte   = 45;
  localparam int SingleSample = 52;
  localparam int GroupLen     = 5;
  localparam int TripleLen    = 3;

  typedef struct packed {
    logic [6:0] pos;
    logic [9:0] code;
    logic       is_abs;
    logic       last;
  } op_t;

  function automatic logic [3:0] chan_map(input logic [6:0] pos);
    logic [6:0] rel;
    logic [3:0] ch;
    rel = 7'd0;
    if (pos < 7'd12) begin
      ch = pos[3:0];
    end else if (pos < 7'(SingleSample)) begin
      rel = pos - 7'd12;
      ch  = {1'b0, rel[2:0]};
    end else if (pos == 7'(SingleSample)) begin
      ch = 4'd8;
    end else if (pos < 7'(CycleSamples)) begin
      rel = pos - 7'(SingleSample + 1);
      ch  = {1'b0, rel[2:0]};
    end else begin
      ch = 4'd0;
    end
    return ch;
  endfunction

  function automatic logic [ChIdxW-1:0] chan_idx(input logic [6:0] pos);
    logic [3:0]        ch;
    logic [ChIdxW-1:0] idx;
    ch  = chan_map(pos);
    idx = '0;
    for (int k = 0; k < 16; k++) begin
      if (ch == 4'(k)) begin
        idx = ChIdxW'(k % NumChannels);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tdsd_ram.sv
`default_nettype none

module tdsd_ram #(
  parameter int Width = 16,
  parameter int Depth = 12,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/tdsd_unpack.sv
`default_nettype none

module tdsd_unpack (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire logic [7:0]    s_byte_i,
  input  wire logic          s_end_i,
  output logic               op_valid_o,
  output tdsd_pkg::op_t      op_o,
  input  wire logic          op_ready_i
);

  logic [6:0] bp_q, bp_d;
  logic [6:0] sp_q, sp_d;
  logic [2:0] sub_q, sub_d;
  logic [7:0] held_q [4];
  logic [7:0] held_d [4];

  logic       gen_valid_q, gen_valid_d;
  logic [1:0] gen_i_q, gen_i_d;
  logic [1:0] gen_lasti_q, gen_lasti_d;
  logic       gen_abs_q, gen_abs_d;
  logic [6:0] gen_pos_q, gen_pos_d;
  logic [9:0] gen_code_q [4];
  logic [9:0] gen_code_d [4];

  logic in_ref, is_single, completes, s_fire, op_fire, gen_done, gen_free;

  assign in_ref    = bp_q < 7'(tdsd_pkg::RefBytes);
  assign is_single = bp_q == 7'(tdsd_pkg::SingleByte);
  assign completes = in_ref ? (sub_q == 3'(tdsd_pkg::GroupLen - 1))
                            : (is_single || sub_q == 3'(tdsd_pkg::TripleLen - 1));

  assign op_valid_o  = gen_valid_q;
  assign op_o.pos    = gen_pos_q + {5'd0, gen_i_q};
  assign op_o.code   = gen_code_q[gen_i_q];
  assign op_o.is_abs = gen_abs_q;
  assign op_o.last   = gen_i_q == gen_lasti_q;

  assign op_fire  = gen_valid_q && op_ready_i;
  assign gen_done = op_fire && op_o.last;
  assign gen_free = !gen_valid_q || gen_done;

  assign s_ready_o = !completes || gen_free;
  assign s_fire    = s_valid_i && s_ready_o;

  always_comb begin
    bp_d        = bp_q;
    sp_d        = sp_q;
    sub_d       = sub_q;
    held_d      = held_q;
    gen_valid_d = gen_valid_q;
    gen_i_d     = gen_i_q;
    gen_lasti_d = gen_lasti_q;
    gen_abs_d   = gen_abs_q;
    gen_pos_d   = gen_pos_q;
    gen_code_d  = gen_code_q;

    if (gen_done) begin
      gen_valid_d = 1'b0;
    end else if (op_fire) begin
      gen_i_d = gen_i_q + 2'd1;
    end

    if (s_fire) begin
      if (s_end_i) begin
        bp_d  = 7'd0;
        sp_d  = 7'd0;
        sub_d = 3'd0;
      end else begin
        if (completes) begin
          sub_d       = 3'd0;
          gen_valid_d = 1'b1;
          gen_i_d     = 2'd0;
          gen_abs_d   = in_ref;
          if (in_ref) begin
            gen_lasti_d = 2'd3;
            gen_pos_d   = sp_q;
            sp_d        = sp_q + 7'd4;
            for (int i = 0; i < 4; i++) begin
              gen_code_d[i] = {s_byte_i[7-2*i -: 2], held_q[i]};
            end
          end else if (is_single) begin
            gen_lasti_d   = 2'd0;
            gen_pos_d     = 7'(tdsd_pkg::SingleSample);
            sp_d          = 7'(tdsd_pkg::SingleSample + 1);
            gen_code_d[0] = {4'd0, s_byte_i[5:0]};
          end else begin
            gen_lasti_d   = 2'd3;
            gen_pos_d     = sp_q;
            sp_d          = sp_q + 7'd4;
            gen_code_d[0] = {4'd0, held_q[0][5:0]};
            gen_code_d[1] = {4'd0, held_q[1][5:0]};
            gen_code_d[2] = {4'd0, s_byte_i[5:0]};
            gen_code_d[3] = {4'd0, held_q[0][7:6], held_q[1][7:6], s_byte_i[7:6]};
          end
        end else begin
          sub_d              = sub_q + 3'd1;
          held_d[sub_q[1:0]] = s_byte_i;
        end
        if (bp_q == 7'(tdsd_pkg::CycleBytes - 1)) begin
          bp_d = 7'd0;
          sp_d = 7'd0;
        end else begin
          bp_d = bp_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q        <= 7'd0;
      sp_q        <= 7'd0;
      sub_q       <= 3'd0;
      gen_valid_q <= 1'b0;
      gen_i_q     <= 2'd0;
      gen_lasti_q <= 2'd0;
    end else begin
      bp_q        <= bp_d;
      sp_q        <= sp_d;
      sub_q       <= sub_d;
      gen_valid_q <= gen_valid_d;
      gen_i_q     <= gen_i_d;
      gen_lasti_q <= gen_lasti_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q     <= held_d;
    gen_abs_q  <= gen_abs_d;
    gen_pos_q  <= gen_pos_d;
    gen_code_q <= gen_code_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/tdsd_update.sv
`default_nettype none

module tdsd_update (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          op_valid_i,
  input  tdsd_pkg::op_t      op_i,
  output logic               op_ready_o,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output logic [15:0]        m_value_o,
  output logic [3:0]         m_chan_o,
  output logic [6:0]         m_pos_o,
  output logic               m_last_o
);

  logic                             a_valid_q;
  tdsd_pkg::op_t                    a_op_q;
  logic [tdsd_pkg::ChIdxW-1:0]      a_idx_q;
  logic                             fwd_hit_q;
  logic [15:0]                      fwd_val_q;
  logic                             rd_ok_q;
  logic [tdsd_pkg::NumChannels-1:0] valid_q;

  logic        out_valid_q;
  logic [15:0] out_value_q;
  logic [3:0]  out_chan_q;
  logic [6:0]  out_pos_q;
  logic        out_last_q;

  logic                        a_adv, op_take;
  logic [tdsd_pkg::ChIdxW-1:0] rd_idx;
  logic [15:0]                 rdata, old_val, mag, new_val;

  assign a_adv      = a_valid_q && (!out_valid_q || m_ready_i);
  assign op_ready_o = !a_valid_q || a_adv;
  assign op_take    = op_valid_i && op_ready_o;
  assign rd_idx     = tdsd_pkg::chan_idx(op_i.pos);

  tdsd_ram #(
    .Width (16),
    .Depth (tdsd_pkg::NumChannels)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (a_adv),
    .waddr_i (a_idx_q),
    .wdata_i (new_val),
    .re_i    (op_take),
    .raddr_i (rd_idx),
    .rdata_o (rdata)
  );

  always_comb begin
    old_val = fwd_hit_q ? fwd_val_q : (rd_ok_q ? rdata : 16'd0);
    mag     = {9'd0, a_op_q.code[4:0], 2'b00};
    if (a_op_q.is_abs) begin
      new_val = {4'd0, a_op_q.code, 2'b00};
    end else if (a_op_q.code[5]) begin
      new_val = old_val + mag;
    end else begin
      new_val = old_val - mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      if (op_take) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv) begin
        out_valid_q      <= 1'b1;
        valid_q[a_idx_q] <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_take) begin
      a_op_q    <= op_i;
      a_idx_q   <= rd_idx;
      fwd_hit_q <= a_adv && (a_idx_q == rd_idx);
      fwd_val_q <= new_val;
      rd_ok_q   <= valid_q[rd_idx];
    end
    if (a_adv) begin
      out_value_q <= new_val;
      out_chan_q  <= tdsd_pkg::chan_map(a_op_q.pos);
      out_pos_q   <= a_op_q.pos;
      out_last_q  <= a_op_q.last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_value_o = out_value_q;
  assign m_chan_o  = out_chan_q;
  assign m_pos_o   = out_pos_q;
  assign m_last_o  = out_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/telemetry_delta_sample_decoder.sv
// Telemetry delta-sample decoder.
// Slave stream: one payload byte per transfer in s_axis_tdata; s_axis_tlast
// marks the trailing packet-number byte, which yields no samples and returns
// the byte and sample positions to the start of a 70-byte cycle.
// Master stream: one decoded sample per transfer; m_axis_tlast flags the final
// sample caused by one input byte.
// A byte that completes a group gives its first sample on m_axis after the
// sample generator, the update stage and the output register; a five-byte
// absolute group gives four samples, a delta triple four, the single delta
// byte one, any other byte none. Samples leave at one per cycle while m_axis
// is ready, set by the read-modify-write of the channel value RAM (one read
// and one write port); a triple gives four samples for three bytes.
// Bytes that complete no group are taken while earlier samples are still
// being produced. A stall on m_axis holds the output register, then the
// update stage, then the byte that would start new samples.
// Reset clears positions, pipeline valids and the per-channel written flags;
// unwritten channels read as zero, so no clearing pass is needed.
`default_nettype none

module telemetry_delta_sample_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] sample_value, [19:16] channel,
                                           // [26:20] frame_position, [31:27] zero
  output logic             m_axis_tlast
);

  logic          op_valid, op_ready;
  tdsd_pkg::op_t op;
  logic [15:0]   value;
  logic [3:0]    chan;
  logic [6:0]    pos;

  tdsd_unpack u_unpack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_byte_i   (s_axis_tdata),
    .s_end_i    (s_axis_tlast),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_ready_i (op_ready)
  );

  tdsd_update u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_ready_o (op_ready),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_value_o  (value),
    .m_chan_o   (chan),
    .m_pos_o    (pos),
    .m_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, pos, chan, value};

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pos < 7'(tdsd_pkg::CycleSamples))
    else $error("frame position out of range");

  a_chan_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> chan == tdsd_pkg::chan_map(pos))
    else $error("channel does not match position");

  a_abs_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && pos < 7'd12) |-> (value[1:0] == 2'b00 && value[15:12] == 4'd0))
    else $error("absolute sample badly formed");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !op_valid |-> s_axis_tready)
    else $error("input stalled with no samples pending");
`endif

endmodule

`default_nettype wire

// File: test/telemetry_delta_sample_decoder_tb.sv
`timescale 1ns / 100ps

module telemetry_delta_sample_decoder_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic [15:0] value;
    logic [3:0]  chan;
    logic [6:0]  pos;
    logic        is_last;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  logic        stall_en = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  // decoder state as seen from the stream
  logic [3:0]  chan_of [tdsd_pkg::CycleSamples];
  logic [15:0] kept_value [tdsd_pkg::NumChannels];
  logic [7:0]  held [4];
  int unsigned byte_pos;
  int unsigned samp_pos;
  sample_t     expected_samples [$];

  telemetry_delta_sample_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void push_absolute(input int unsigned p, input logic [9:0] raw,
                                        input logic lst);
    logic [15:0] v;
    v = {4'd0, raw, 2'd0};
    kept_value[chan_of[p] % tdsd_pkg::NumChannels] = v;
    expected_samples.push_back('{v, chan_of[p], 7'(p), lst});
  endfunction

  function automatic void push_delta(input int unsigned p, input logic [5:0] code,
                                     input logic lst);
    int unsigned idx;
    logic [15:0] mag;
    logic [15:0] v;
    idx = chan_of[p] % tdsd_pkg::NumChannels;
    mag = {9'd0, code[4:0], 2'd0};
    v = code[5] ? kept_value[idx] + mag : kept_value[idx] - mag;
    kept_value[idx] = v;
    expected_samples.push_back('{v, chan_of[p], 7'(p), lst});
  endfunction

  task automatic predict_samples(input logic [7:0] b, input logic eop);
    int unsigned j;
    int unsigned n;
    int unsigned i;
    logic [5:0] d [4];
    n = 0;
    if (eop) begin
      byte_pos = 0;
      samp_pos = 0;
      return;
    end
    if (byte_pos < tdsd_pkg::RefBytes) begin
      j = byte_pos % tdsd_pkg::GroupLen;
      if (j < tdsd_pkg::GroupLen - 1) begin
        held[j] = b;
      end else begin
        for (i = 0; i < 4; i++)
          push_absolute(samp_pos + i, {b[7 - 2 * i -: 2], held[i]}, i == 3);
        n = 4;
      end
    end else if (byte_pos == tdsd_pkg::SingleByte) begin
      push_delta(tdsd_pkg::SingleSample, b[5:0], 1'b1);
      n = 1;
    end else begin
      j = (byte_pos < tdsd_pkg::SingleByte) ? byte_pos - tdsd_pkg::RefBytes
                                            : byte_pos - tdsd_pkg::SingleByte - 1;
      j = j % tdsd_pkg::TripleLen;
      if (j < tdsd_pkg::TripleLen - 1) begin
        held[j] = b;
      end else begin
        d[0] = held[0][5:0];
        d[1] = held[1][5:0];
        d[2] = b[5:0];
        d[3] = {held[0][7:6], held[1][7:6], b[7:6]};
        for (i = 0; i < 4; i++)
          push_delta(samp_pos + i, d[i], i == 3);
        n = 4;
      end
    end
    samp_pos += n;
    byte_pos += 1;
    if (byte_pos >= tdsd_pkg::CycleBytes) begin
      byte_pos = 0;
      samp_pos = 0;
    end
    if (samp_pos >= tdsd_pkg::CycleSamples)
      samp_pos = 0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eop);
    while (stall_en && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eop;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_samples(b, eop);
  endtask

  task automatic test_group_extremes();
    send_byte(8'h00, 1'b1);
    repeat (5) send_byte(8'hFF, 1'b0);
    repeat (4) send_byte(8'h00, 1'b0);
    send_byte(8'h1B, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hE4, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_trailing_mid_group();
    repeat (3) send_byte(8'($urandom), 1'b0);
    send_byte(8'h00, 1'b1);
    repeat (5) send_byte(8'($urandom), 1'b0);
    send_byte(8'h7E, 1'b1);
  endtask

  // full cycle with single delta, wrap into the next cycle, drop mid triple
  task automatic test_cycle_wrap();
    logic [7:0] pattern [9];
    int unsigned k;
    pattern = '{8'hFF, 8'h00, 8'hA5, 8'h3F, 8'hC0, 8'h5A, 8'h20, 8'h1F, 8'hE0};
    for (k = 0; k < tdsd_pkg::CycleBytes; k++) begin
      if (k < tdsd_pkg::RefBytes)
        send_byte(8'h00, 1'b0);
      else if (k == tdsd_pkg::SingleByte)
        send_byte(8'h1F, 1'b0);
      else
        send_byte(pattern[k % 9], 1'b0);
    end
    for (k = 0; k < tdsd_pkg::RefBytes + 2; k++)
      send_byte(pattern[(k + 4) % 9], 1'b0);
    send_byte(8'h81, 1'b1);
    repeat (5) send_byte(8'h3C, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random_frames(input int unsigned n_items, input logic idle);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    logic [7:0] b;
    stall_en <= idle;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(1, 20);
        2, 3, 4: len = $urandom_range(21, 69);
        default: len = $urandom_range(70, 145);
      endcase
      if (sent + len + 1 > n_items)
        len = n_items - sent - 1;
      for (k = 0; k < len; k++) begin
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        send_byte(b, 1'b0);
      end
      send_byte(8'($urandom), 1'b1);
      sent += len + 1;
      if ($urandom_range(0, 4) == 0) begin
        send_byte(8'($urandom), 1'b1);
        sent += 1;
      end
    end
  endtask

  always @(posedge clk_i) begin
    sample_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("unexpected sample: value %h ch %0d pos %0d last %b",
                   m_axis_tdata[15:0], m_axis_tdata[19:16], m_axis_tdata[26:20],
                   m_axis_tlast);
      end else begin
        e = expected_samples.pop_front();
        if (m_axis_tdata[15:0] !== e.value || m_axis_tdata[19:16] !== e.chan ||
            m_axis_tdata[26:20] !== e.pos || m_axis_tdata[31:27] !== 5'd0 ||
            m_axis_tlast !== e.is_last) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("mismatch: exp %h ch %0d pos %0d last %b, got %h %0d %0d %b pad %h",
                     e.value, e.chan, e.pos, e.is_last,
                     m_axis_tdata[15:0], m_axis_tdata[19:16], m_axis_tdata[26:20],
                     m_axis_tlast, m_axis_tdata[31:27]);
        end
      end
    end
    m_axis_tready <= !stall_en || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    for (p = 0; p < tdsd_pkg::CycleSamples; p++) begin
      if (p < 12)
        chan_of[p] = 4'(p);
      else if (p < tdsd_pkg::SingleSample)
        chan_of[p] = 4'((p - 12) % 8);
      else if (p == tdsd_pkg::SingleSample)
        chan_of[p] = 4'd8;
      else
        chan_of[p] = 4'((p - tdsd_pkg::SingleSample - 1) % 8);
    end
    for (p = 0; p < tdsd_pkg::NumChannels; p++)
      kept_value[p] = 16'd0;
    byte_pos = 0;
    samp_pos = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_group_extremes();
    test_trailing_mid_group();
    test_cycle_wrap();
    test_random_frames(45, 1'b1);
    test_random_frames(45, 1'b0);
    test_random_frames(40, 1'b1);
    s_axis_tvalid <= 1'b0;

    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
